// ===== rtl/lgfb_pkg.sv =====
// lgfb_pkg: shared types and constants for the lightmap gutter fill and blur core
// used by lgfb_div3 and lightmap_gutter_fill_and_blur_core; no dependencies
`default_nettype none

package lgfb_pkg;

	// stream payload widths
	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// request kinds carried on tuser
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_PROCESS = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_MAX_FILL     = 2'd2;
	localparam logic [1:0] CFG_RAD_LIMIT    = 2'd3;

	// register reset values
	localparam logic [8:0]  FRAME_DIM_RST = 9'd256;
	localparam logic [7:0]  MAX_FILL_RST  = 8'd7;
	localparam logic [15:0] RAD_LIMIT_RST = 16'd12288;

	// first bit of the square root search, a power of four whose next power lies above any sum of three squares
	localparam logic [33:0] SQRT_BIT0 = 34'h1_0000_0000;

	// one stored pixel
	typedef struct packed {
		logic             valid;
		logic             covered;
		logic [15:0]      tri_idx;
		logic [2:0][15:0] color;
	} pix_t;

	// three-lane divider request and response
	typedef struct packed {
		logic [2:0][31:0] num;
		logic [16:0]      den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [2:0][15:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/lgfb_div3.sv =====
// lgfb_div3: three-lane restoring divider sharing one divisor, one bit per cycle
// depends on lgfb_pkg for the request and response structs
`default_nettype none

module lgfb_div3 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire lgfb_pkg::div_req_t req,
	output lgfb_pkg::div_rsp_t     rsp
);

	logic [2:0][31:0] num_q;
	logic [2:0][17:0] rem_q;
	logic [16:0]      den_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [2:0][17:0] trial;
	logic [2:0]       fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			trial[l] = {rem_q[l][16:0], num_q[l][31]};
			fits[l]  = trial[l] >= {1'b0, den_q};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			for (int l = 0; l < 3; l++) begin
				if (fits[l]) begin
					rem_q[l] <= trial[l] - {1'b0, den_q};
					num_q[l] <= {num_q[l][30:0], 1'b1};
				end else begin
					rem_q[l] <= trial[l];
					num_q[l] <= {num_q[l][30:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		for (int l = 0; l < 3; l++) begin
			rsp.quo[l] = num_q[l][15:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lightmap_gutter_fill_and_blur_core.sv =====
// Lightmap gutter fill and 3x3 box blur over a frame held in on-chip memory.
// After reset the core sweeps the pixel memory once to clear the valid and
// covered flags, one entry per cycle (MAX_WIDTH*MAX_HEIGHT rounded up to powers
// of two, 65536 entries by default); s_tready stays low meanwhile. Every
// request then runs alone through one sequencer around a pixel memory with
// a registered read port. An uncovered load, an out-of-range load or read, or
// an unused mode never leaves the idle state. A covered load squares its
// colors and the limit; when the radiance is rescaled it also runs 17 square
// root steps, scales each color by the limit and divides by the length. A
// process request runs fill passes over each frame pixel, the memory port
// walking up to four neighbors of an empty one; then the blur reads up to
// nine window pixels and runs the divider for each covered pixel, then a
// copy pass writes the blurred colors back.
// Depends on lgfb_pkg and lgfb_div3.
`default_nettype none

module lightmap_gutter_fill_and_blur_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// pos_x, pos_y, covered, in_red, in_green, in_blue, tri_index, zero fill
	input  wire logic [lgfb_pkg::IN_DATA_W-1:0] s_tdata,
	// mode
	input  wire logic [lgfb_pkg::IN_USER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// out_red, out_green, out_blue, out_valid, passes_run, zero fill
	output logic [lgfb_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [lgfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lgfb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CMPW  = ((XW + 1) > 9) ? (XW + 1) : 9;
	localparam int CMPH  = ((YW + 1) > 9) ? (YW + 1) : 9;
	localparam int NXW   = CMPW + 1;
	localparam int NYW   = CMPH + 1;

	typedef enum logic [18:0] {
		S_CLEAR  = 19'd1,
		S_IDLE   = 19'd2,
		S_LMUL   = 19'd4,
		S_LSQRT  = 19'd8,
		S_LSCALE = 19'd16,
		S_LDIV   = 19'd32,
		S_RDWAIT = 19'd64,
		S_FRD    = 19'd128,
		S_FCHK   = 19'd256,
		S_FNB    = 19'd512,
		S_FNBCHK = 19'd1024,
		S_FADV   = 19'd2048,
		S_FEND   = 19'd4096,
		S_BRD    = 19'd8192,
		S_BCHK   = 19'd16384,
		S_BNB    = 19'd32768,
		S_BNBCHK = 19'd65536,
		S_BDIV   = 19'd131072,
		S_BADV   = 19'd262144
	} state_t;

	// copy pass states reuse the fill position counters
	typedef enum logic [1:0] {
		C_OFF = 2'b01,
		C_ON  = 2'b10
	} copy_t;

	state_t state_q;
	copy_t  copy_q;
	logic   copy_wr_q;

	// configuration registers
	logic [8:0]  frame_width_q;
	logic [8:0]  frame_height_q;
	logic [7:0]  max_fill_q;
	logic [15:0] rad_limit_q;

	// output register
	logic                           m_tvalid_q;
	logic [lgfb_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// memories
	lgfb_pkg::pix_t   pix_mem [DEPTH];
	logic [2:0][15:0] blur_mem [DEPTH];
	lgfb_pkg::pix_t   pix_rd_q;
	logic [2:0][15:0] bl_rd_q;
	logic             pm_we;
	logic [AW-1:0]    pm_waddr;
	logic [AW-1:0]    pm_raddr;
	lgfb_pkg::pix_t   pm_wdata;
	logic             bm_we;

	// load datapath
	logic [2:0][15:0] ld_col_q;
	logic [15:0]      ld_tri_q;
	logic [AW-1:0]    ld_addr_q;
	logic [2:0]       step_q;
	logic [31:0]      mul_q;
	logic [33:0]      ss_q;
	logic [33:0]      sq_v_q;
	logic [33:0]      sq_res_q;
	logic [33:0]      sq_bit_q;
	logic [2:0][31:0] num_q;
	logic [15:0]      mul_a;
	logic [15:0]      mul_b;
	logic [31:0]      mul_p;
	logic             need_scale;
	logic [33:0]      sq_try;

	// frame walk
	logic [XW:0]      fw_q;
	logic [YW:0]      fh_q;
	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [8:0]       d_q;
	logic [8:0]       passes_q;
	logic             any_q;
	logic [1:0]       k_q;
	lgfb_pkg::pix_t   self_q;
	logic [AW-1:0]    self_addr;
	logic             last_x;
	logic             last_y;

	// fill neighbor
	logic [NXW-1:0]   nb_x;
	logic [NYW-1:0]   nb_y;
	logic             nb_in;
	logic [NXW-1:0]   xe;
	logic [NYW-1:0]   ye;
	logic [NXW-1:0]   dxe;
	logic [NYW-1:0]   dye;

	// blur window
	logic [XW-1:0]    wk_q;
	logic [XW-1:0]    wk1_q;
	logic [YW-1:0]    wl_q;
	logic [YW-1:0]    wl0_q;
	logic [YW-1:0]    wl1_q;
	logic [2:0][19:0] sum_q;
	logic [3:0]       cnt_q;
	logic             nb_match;
	logic [XW:0]      fw_m1;
	logic [YW:0]      fh_m1;

	// divider
	logic               div_start_q;
	lgfb_pkg::div_req_t div_req;
	lgfb_pkg::div_rsp_t div_rsp;

	// input decode
	logic [7:0]       in_px;
	logic [7:0]       in_py;
	logic             in_cov;
	logic [2:0][15:0] in_col;
	logic [15:0]      in_tri;
	logic [1:0]       in_mode;
	logic             in_acc;
	logic             in_inside;
	logic [CMPW-1:0]  in_px_e;
	logic [CMPH-1:0]  in_py_e;
	logic [AW-1:0]    in_addr;
	logic [CMPW-1:0]  fw_raw;
	logic [CMPH-1:0]  fh_raw;
	logic [CMPW-1:0]  fw_eff;
	logic [CMPH-1:0]  fh_eff;

	assign in_px     = s_tdata[7:0];
	assign in_py     = s_tdata[15:8];
	assign in_cov    = s_tdata[16];
	assign in_col[0] = s_tdata[32:17];
	assign in_col[1] = s_tdata[48:33];
	assign in_col[2] = s_tdata[64:49];
	assign in_tri    = s_tdata[80:65];
	assign in_mode   = s_tuser;
	assign in_px_e   = CMPW'(in_px);
	assign in_py_e   = CMPH'(in_py);
	assign in_inside = (in_px_e < CMPW'(MAX_WIDTH)) && (in_py_e < CMPH'(MAX_HEIGHT));
	assign in_addr   = {in_py_e[YW-1:0], in_px_e[XW-1:0]};

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// effective frame size, zero acts as one and oversize as the maximum
	assign fw_raw = CMPW'(frame_width_q);
	assign fh_raw = CMPH'(frame_height_q);
	assign fw_eff = (fw_raw == '0) ? CMPW'(1) :
		((fw_raw > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : fw_raw);
	assign fh_eff = (fh_raw == '0) ? CMPH'(1) :
		((fh_raw > CMPH'(MAX_HEIGHT)) ? CMPH'(MAX_HEIGHT) : fh_raw);

	// position walk
	assign self_addr = {y_q, x_q};
	assign last_x    = ({1'b0, x_q} + 1'b1) == fw_q;
	assign last_y    = ({1'b0, y_q} + 1'b1) == fh_q;
	assign fw_m1     = fw_q - 1'b1;
	assign fh_m1     = fh_q - 1'b1;

	// fill neighbor in order left, right, below, above
	assign xe  = NXW'(x_q);
	assign ye  = NYW'(y_q);
	assign dxe = NXW'(d_q);
	assign dye = NYW'(d_q);
	always_comb begin
		nb_x  = xe;
		nb_y  = ye;
		nb_in = 1'b0;
		case (k_q)
			2'd0: begin
				nb_x  = xe - dxe;
				nb_in = xe >= dxe;
			end
			2'd1: begin
				nb_x  = xe + dxe;
				nb_in = nb_x < NXW'(fw_q);
			end
			2'd2: begin
				nb_y  = ye + dye;
				nb_in = nb_y < NYW'(fh_q);
			end
			default: begin
				nb_y  = ye - dye;
				nb_in = ye >= dye;
			end
		endcase
	end

	assign nb_match = pix_rd_q.valid && pix_rd_q.covered &&
		(pix_rd_q.tri_idx == self_q.tri_idx);

	// shared multiplier for squares and scaling
	always_comb begin
		if (state_q == S_LMUL && step_q == 3'd3) begin
			mul_a = rad_limit_q;
			mul_b = rad_limit_q;
		end else if (state_q == S_LSCALE) begin
			mul_a = ld_col_q[step_q[1:0]];
			mul_b = rad_limit_q;
		end else begin
			mul_a = ld_col_q[step_q[1:0]];
			mul_b = ld_col_q[step_q[1:0]];
		end
	end
	assign mul_p      = mul_a * mul_b;
	assign need_scale = ss_q > {2'b00, mul_q};
	assign sq_try     = sq_res_q + sq_bit_q;

	// divider operands
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			div_req.num[l] = (state_q == S_BDIV) ? 32'(sum_q[l]) : num_q[l];
		end
		div_req.den = (state_q == S_BDIV) ? 17'(cnt_q) : sq_res_q[16:0];
	end

	lgfb_div3 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// pixel memory read address
	always_comb begin
		case (state_q)
			S_IDLE:  pm_raddr = in_addr;
			S_FNB:   pm_raddr = {nb_y[YW-1:0], nb_x[XW-1:0]};
			S_BNB:   pm_raddr = {wl_q, wk_q};
			default: pm_raddr = self_addr;
		endcase
	end

	// pixel memory write
	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = self_addr;
		pm_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				pm_we    = 1'b1;
				pm_waddr = ld_addr_q;
			end
			S_IDLE: begin
				if (in_acc && in_mode == lgfb_pkg::MODE_LOAD && in_inside && !in_cov) begin
					pm_we            = 1'b1;
					pm_waddr         = in_addr;
					pm_wdata.tri_idx = in_tri;
				end
			end
			S_LMUL: begin
				if (step_q == 3'd4 && !need_scale) begin
					pm_we    = 1'b1;
					pm_waddr = ld_addr_q;
					pm_wdata = {1'b1, 1'b1, ld_tri_q, ld_col_q};
				end
			end
			S_LDIV: begin
				if (div_rsp.done) begin
					pm_we    = 1'b1;
					pm_waddr = ld_addr_q;
					pm_wdata = {1'b1, 1'b1, ld_tri_q, div_rsp.quo};
				end
			end
			S_FNBCHK: begin
				if (pix_rd_q.valid) begin
					pm_we    = 1'b1;
					pm_wdata = {1'b1, self_q.covered, self_q.tri_idx, pix_rd_q.color};
				end
			end
			S_BADV: begin
				if (copy_q == C_ON && copy_wr_q && pix_rd_q.valid && pix_rd_q.covered) begin
					pm_we          = 1'b1;
					pm_wdata       = pix_rd_q;
					pm_wdata.color = bl_rd_q;
				end
			end
			default: pm_we = 1'b0;
		endcase
	end

	assign bm_we = (state_q == S_BDIV) && div_rsp.done;

	// memories
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pix_mem[pm_waddr] <= pm_wdata;
		end
		pix_rd_q <= pix_mem[pm_raddr];
	end

	always_ff @(posedge clk) begin
		if (bm_we) begin
			blur_mem[self_addr] <= div_rsp.quo;
		end
		bl_rd_q <= blur_mem[pm_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= lgfb_pkg::FRAME_DIM_RST;
			frame_height_q <= lgfb_pkg::FRAME_DIM_RST;
			max_fill_q     <= lgfb_pkg::MAX_FILL_RST;
			rad_limit_q    <= lgfb_pkg::RAD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lgfb_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
				lgfb_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[8:0];
				lgfb_pkg::CFG_MAX_FILL:     max_fill_q     <= cfg_data[7:0];
				lgfb_pkg::CFG_RAD_LIMIT:    rad_limit_q    <= cfg_data;
				default:                    rad_limit_q    <= rad_limit_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			copy_q      <= C_OFF;
			copy_wr_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
			div_start_q <= 1'b0;
			ld_addr_q   <= '0;
			step_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			k_q         <= '0;
			d_q         <= '0;
			passes_q    <= '0;
			any_q       <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				// clearing sweep, address held in the load address register
				S_CLEAR: begin
					ld_addr_q <= ld_addr_q + 1'b1;
					if (ld_addr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						m_tdata_q <= '0;
						case (in_mode)
							lgfb_pkg::MODE_LOAD: begin
								if (in_inside && in_cov) begin
									ld_col_q  <= in_col;
									ld_tri_q  <= in_tri;
									ld_addr_q <= in_addr;
									ss_q      <= '0;
									step_q    <= '0;
									state_q   <= S_LMUL;
								end else begin
									m_tvalid_q <= 1'b1;
								end
							end
							lgfb_pkg::MODE_PROCESS: begin
								fw_q     <= fw_eff[XW:0];
								fh_q     <= fh_eff[YW:0];
								x_q      <= '0;
								y_q      <= '0;
								d_q      <= 9'd1;
								any_q    <= 1'b0;
								passes_q <= '0;
								copy_q   <= C_OFF;
								state_q  <= S_FRD;
							end
							lgfb_pkg::MODE_READ: begin
								if (in_inside) begin
									state_q <= S_RDWAIT;
								end else begin
									m_tvalid_q <= 1'b1;
								end
							end
							default: m_tvalid_q <= 1'b1;
						endcase
					end
				end
				S_RDWAIT: begin
					m_tvalid_q <= 1'b1;
					if (pix_rd_q.valid) begin
						m_tdata_q <= {15'd0, 1'b1, pix_rd_q.color};
					end
					state_q <= S_IDLE;
				end
				// squares of the color and of the limit
				S_LMUL: begin
					mul_q  <= mul_p;
					step_q <= step_q + 3'd1;
					if (step_q >= 3'd1 && step_q <= 3'd3) begin
						ss_q <= ss_q + {2'b00, mul_q};
					end
					if (step_q == 3'd4) begin
						if (need_scale) begin
							sq_v_q   <= ss_q;
							sq_res_q <= '0;
							sq_bit_q <= lgfb_pkg::SQRT_BIT0;
							state_q  <= S_LSQRT;
						end else begin
							m_tvalid_q <= 1'b1;
							state_q    <= S_IDLE;
						end
					end
				end
				// vector length, two bits of the radicand per cycle
				S_LSQRT: begin
					if (sq_v_q >= sq_try) begin
						sq_v_q   <= sq_v_q - sq_try;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q[0]) begin
						step_q  <= '0;
						state_q <= S_LSCALE;
					end
				end
				// color times limit, then divide by the length
				S_LSCALE: begin
					num_q[step_q[1:0]] <= mul_p;
					step_q             <= step_q + 3'd1;
					if (step_q == 3'd2) begin
						div_start_q <= 1'b1;
						state_q     <= S_LDIV;
					end
				end
				S_LDIV: begin
					if (div_rsp.done) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				// dilation pass
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					self_q <= pix_rd_q;
					k_q    <= '0;
					state_q <= pix_rd_q.valid ? S_FADV : S_FNB;
				end
				S_FNB: begin
					if (nb_in) begin
						state_q <= S_FNBCHK;
					end else if (k_q == 2'd3) begin
						state_q <= S_FADV;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_FNBCHK: begin
					if (pix_rd_q.valid) begin
						any_q   <= 1'b1;
						state_q <= S_FADV;
					end else if (k_q == 2'd3) begin
						state_q <= S_FADV;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_FNB;
					end
				end
				S_FADV: begin
					state_q <= S_FRD;
					if (!last_y) begin
						y_q <= y_q + 1'b1;
					end else begin
						y_q <= '0;
						if (!last_x) begin
							x_q <= x_q + 1'b1;
						end else begin
							x_q     <= '0;
							state_q <= S_FEND;
						end
					end
				end
				S_FEND: begin
					passes_q <= passes_q + 9'd1;
					any_q    <= 1'b0;
					if (!any_q || d_q > {1'b0, max_fill_q}) begin
						state_q <= S_BRD;
					end else begin
						d_q     <= d_q + 9'd1;
						state_q <= S_FRD;
					end
				end
				// blur, and the copy pass that follows it
				S_BRD: begin
					copy_wr_q <= 1'b0;
					state_q   <= S_BCHK;
				end
				S_BCHK: begin
					self_q <= pix_rd_q;
					if (copy_q == C_ON) begin
						copy_wr_q <= 1'b1;
						state_q   <= S_BADV;
					end else if (!(pix_rd_q.valid && pix_rd_q.covered)) begin
						state_q <= S_BADV;
					end else begin
						wk_q    <= (x_q == '0) ? '0 : x_q - 1'b1;
						wk1_q   <= last_x ? fw_m1[XW-1:0] : x_q + 1'b1;
						wl_q    <= (y_q == '0) ? '0 : y_q - 1'b1;
						wl0_q   <= (y_q == '0) ? '0 : y_q - 1'b1;
						wl1_q   <= last_y ? fh_m1[YW-1:0] : y_q + 1'b1;
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_BNB;
					end
				end
				S_BNB: state_q <= S_BNBCHK;
				S_BNBCHK: begin
					if (nb_match) begin
						for (int c = 0; c < 3; c++) begin
							sum_q[c] <= sum_q[c] + 20'(pix_rd_q.color[c]);
						end
						cnt_q <= cnt_q + 4'd1;
					end
					state_q <= S_BNB;
					if (wl_q != wl1_q) begin
						wl_q <= wl_q + 1'b1;
					end else if (wk_q != wk1_q) begin
						wk_q <= wk_q + 1'b1;
						wl_q <= wl0_q;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_BDIV;
					end
				end
				S_BDIV: begin
					if (div_rsp.done) begin
						state_q <= S_BADV;
					end
				end
				S_BADV: begin
					copy_wr_q <= 1'b0;
					state_q   <= S_BRD;
					if (!last_y) begin
						y_q <= y_q + 1'b1;
					end else begin
						y_q <= '0;
						if (!last_x) begin
							x_q <= x_q + 1'b1;
						end else begin
							x_q <= '0;
							if (copy_q == C_ON) begin
								copy_q     <= C_OFF;
								m_tvalid_q <= 1'b1;
								m_tdata_q  <= {6'd0, passes_q, 49'd0};
								state_q    <= S_IDLE;
							end else begin
								copy_q <= C_ON;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lgfb_checker.sv =====
// lgfb_checker: port-level checks on the lightmap gutter fill and blur core
// depends on nothing but the core's ports; bound to the core at the end
`default_nettype none

module lgfb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// no request taken while a result is stuck in the output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("request taken with output register full");

	// an invalid pixel reads as zero color
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[48] |-> m_tdata[47:0] == 48'd0)
		else $error("color on an invalid pixel");

	// a pass count never rides with pixel data
	a_pass_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[57:49] != 9'd0) |-> m_tdata[48:0] == 49'd0)
		else $error("pass count mixed with pixel fields");

endmodule

bind lightmap_gutter_fill_and_blur_core lgfb_checker u_lgfb_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for lightmap_gutter_fill_and_blur_core, with a frame model,
// a queued stream driver and a result monitor; depends on lgfb_pkg and the core rtl
`timescale 1ns / 100ps

module tb_top;

	localparam int NPIX        = 65536;
	localparam int STALL_LIMIT = 400000;

	typedef struct {
		logic [1:0]  mode;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic        covered;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] tri_index;
	} pixel_req_t;

	// fields from the highest bit down, matching m_tdata[57:0]
	typedef struct packed {
		logic [8:0]  passes;
		logic        valid;
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} pixel_rsp_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [lgfb_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [lgfb_pkg::IN_USER_W-1:0]  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [lgfb_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_we;
	logic [lgfb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lgfb_pkg::CFG_DATA_W-1:0] cfg_data;

	lightmap_gutter_fill_and_blur_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// frame model
	logic [15:0] frm_color [3][NPIX];
	logic [15:0] frm_blur  [3][NPIX];
	bit          frm_valid [NPIX];
	bit          frm_cov   [NPIX];
	logic [15:0] frm_tri   [NPIX];
	logic [8:0]  reg_width;
	logic [8:0]  reg_height;
	logic [7:0]  reg_max_fill;
	logic [15:0] reg_rad_limit;

	pixel_req_t pending_reqs[$];
	pixel_rsp_t expected_pixels[$];
	int  errors;
	int  req_count;
	int  quiet_cycles;
	bit  req_taken;
	bit  hold_send;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  rx_holdoff_req;
	int  rx_holdoff_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic int eff_dim(logic [8:0] v);
		if (v == 0) return 1;
		if (v > 256) return 256;
		return v;
	endfunction

	// one dilation pass at distance d, in place, column-major
	function automatic bit dilate_pass(int d, int fw, int fh);
		int dx [4] = '{-1, 1, 0, 0};
		int dy [4] = '{0, 0, 1, -1};
		bit any = 0;
		int idx, nx, ny, n;
		for (int x = 0; x < fw; x++) begin
			for (int y = 0; y < fh; y++) begin
				idx = y * 256 + x;
				if (frm_valid[idx]) continue;
				for (int k = 0; k < 4; k++) begin
					nx = x + dx[k] * d;
					ny = y + dy[k] * d;
					if (nx < 0 || nx >= fw || ny < 0 || ny >= fh) continue;
					n = ny * 256 + nx;
					if (!frm_valid[n]) continue;
					for (int c = 0; c < 3; c++) frm_color[c][idx] = frm_color[c][n];
					frm_valid[idx] = 1;
					any = 1;
					break;
				end
			end
		end
		return any;
	endfunction

	// triangle-aware 3x3 mean over covered pixels, from pre-blur colors
	function automatic void blur_frame(int fw, int fh);
		int idx, n, k0, k1, l0, l1;
		int unsigned sum [3];
		int unsigned cnt;
		for (int i = 0; i < fw; i++) begin
			for (int j = 0; j < fh; j++) begin
				idx = j * 256 + i;
				if (!frm_valid[idx] || !frm_cov[idx]) continue;
				sum = '{0, 0, 0};
				cnt = 0;
				k0 = i > 0 ? i - 1 : 0;
				k1 = i + 1 < fw ? i + 1 : fw - 1;
				l0 = j > 0 ? j - 1 : 0;
				l1 = j + 1 < fh ? j + 1 : fh - 1;
				for (int k = k0; k <= k1; k++) begin
					for (int l = l0; l <= l1; l++) begin
						n = l * 256 + k;
						if (!frm_valid[n] || !frm_cov[n]) continue;
						if (frm_tri[n] != frm_tri[idx]) continue;
						for (int c = 0; c < 3; c++) sum[c] += frm_color[c][n];
						cnt++;
					end
				end
				if (cnt == 0) cnt = 1;
				for (int c = 0; c < 3; c++) frm_blur[c][idx] = 16'(sum[c] / cnt);
			end
		end
		for (int i = 0; i < fw; i++) begin
			for (int j = 0; j < fh; j++) begin
				idx = j * 256 + i;
				if (frm_valid[idx] && frm_cov[idx])
					for (int c = 0; c < 3; c++) frm_color[c][idx] = frm_blur[c][idx];
			end
		end
	endfunction

	// expected result of one accepted request, updating the frame model
	function automatic pixel_rsp_t predict_pixel(pixel_req_t q);
		pixel_rsp_t rsp = '0;
		int idx = q.pos_y * 256 + q.pos_x;
		longint unsigned r, g, b, lim, ss, len;
		int fw, fh, d, passes;
		bit any;
		case (q.mode)
			lgfb_pkg::MODE_LOAD: begin
				r = q.red;
				g = q.green;
				b = q.blue;
				lim = reg_rad_limit;
				if (q.covered) begin
					ss = r * r + g * g + b * b;
					if (ss > lim * lim) begin
						len = int_sqrt(ss);
						if (len != 0) begin
							r = r * lim / len;
							g = g * lim / len;
							b = b * lim / len;
						end
					end
				end else begin
					r = 0;
					g = 0;
					b = 0;
				end
				frm_valid[idx] = q.covered;
				frm_cov[idx] = q.covered;
				frm_color[0][idx] = r[15:0];
				frm_color[1][idx] = g[15:0];
				frm_color[2][idx] = b[15:0];
				frm_tri[idx] = q.tri_index;
			end
			lgfb_pkg::MODE_PROCESS: begin
				fw = eff_dim(reg_width);
				fh = eff_dim(reg_height);
				d = 1;
				passes = 0;
				forever begin
					any = dilate_pass(d, fw, fh);
					passes++;
					if (!any || d > reg_max_fill) break;
					d++;
				end
				blur_frame(fw, fh);
				rsp.passes = passes[8:0];
			end
			lgfb_pkg::MODE_READ: begin
				if (frm_valid[idx]) begin
					rsp.red = frm_color[0][idx];
					rsp.green = frm_color[1][idx];
					rsp.blue = frm_color[2][idx];
					rsp.valid = 1'b1;
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	// monitor: check results, then model accepted requests
	always @(posedge clk) begin
		pixel_rsp_t got, exp_rsp;
		pixel_req_t q;
		bit seen;
		seen = 0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = 1;
				got = m_tdata[57:0];
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					errors++;
				end else begin
					exp_rsp = expected_pixels.pop_front();
					if (got.red !== exp_rsp.red || got.green !== exp_rsp.green ||
					    got.blue !== exp_rsp.blue || got.valid !== exp_rsp.valid ||
					    got.passes !== exp_rsp.passes || m_tdata[63:58] !== 6'd0) begin
						$display("%0t: mismatch expected r=%h g=%h b=%h v=%b p=%0d actual %h",
							$time, exp_rsp.red, exp_rsp.green, exp_rsp.blue,
							exp_rsp.valid, exp_rsp.passes, m_tdata);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				seen = 1;
				req_taken = 1;
				q.mode = s_tuser;
				q.pos_x = s_tdata[7:0];
				q.pos_y = s_tdata[15:8];
				q.covered = s_tdata[16];
				q.red = s_tdata[32:17];
				q.green = s_tdata[48:33];
				q.blue = s_tdata[64:49];
				q.tri_index = s_tdata[80:65];
				expected_pixels.push_back(predict_pixel(q));
			end
			quiet_cycles <= seen ? 0 : quiet_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		pixel_req_t q;
		if (arst_n && !(s_tvalid && !req_taken)) begin
			req_taken = 0;
			if (pending_reqs.size() > 0 && !hold_send &&
			    $urandom_range(99) >= send_idle_pct) begin
				q = pending_reqs.pop_front();
				s_tdata <= {7'd0, q.tri_index, q.blue, q.green, q.red, q.covered,
					q.pos_y, q.pos_x};
				s_tuser <= q.mode;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result ready; an armed hold-off keeps ready low until a result waits,
	// then for a long stretch more
	always @(negedge clk) begin
		if (rx_holdoff_left > 0) begin
			rx_holdoff_left--;
			m_tready <= 1'b0;
		end else if (rx_holdoff_req) begin
			m_tready <= 1'b0;
			if (m_tvalid) begin
				rx_holdoff_req = 0;
				rx_holdoff_left = 300;
			end
		end else begin
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || expected_pixels.size() > 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		case (idx)
			lgfb_pkg::CFG_FRAME_WIDTH:  reg_width = 9'(val);
			lgfb_pkg::CFG_FRAME_HEIGHT: reg_height = 9'(val);
			lgfb_pkg::CFG_MAX_FILL:     reg_max_fill = 8'(val);
			default:                    reg_rad_limit = 16'(val);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_frame(int w, int h, int fill, int lim, int idle_sel);
		wait_drained();
		write_reg(lgfb_pkg::CFG_FRAME_WIDTH, w);
		write_reg(lgfb_pkg::CFG_FRAME_HEIGHT, h);
		write_reg(lgfb_pkg::CFG_MAX_FILL, fill);
		write_reg(lgfb_pkg::CFG_RAD_LIMIT, lim);
		case (idle_sel % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	task automatic push_req(int mode, int x, int y, int cov,
		int r, int g, int b, int tri_val);
		pixel_req_t q;
		q.mode = 2'(mode);
		q.pos_x = 8'(x);
		q.pos_y = 8'(y);
		q.covered = 1'(cov);
		q.red = 16'(r);
		q.green = 16'(g);
		q.blue = 16'(b);
		q.tri_index = 16'(tri_val);
		pending_reqs.push_back(q);
		req_count++;
	endtask

	function automatic int rand_chan();
		case ($urandom_range(5))
			0: return 0;
			1: return 16'hffff;
			2: return $urandom_range(8191);
			default: return $urandom_range(65535);
		endcase
	endfunction

	// one frame: loads, pause till drained, then process and reads
	task automatic run_frame(bit rx_press);
		int fw = eff_dim(reg_width);
		int fh = eff_dim(reg_height);
		int n_load = (fw * fh < 40) ? fw * fh : 40;
		int tri_a = $urandom_range(65535);
		for (int i = 0; i < n_load; i++) begin
			if ($urandom_range(9) == 0)
				push_req($urandom_range(3), $urandom_range(255), $urandom_range(255),
					$urandom_range(1), rand_chan(), rand_chan(), rand_chan(),
					$urandom_range(65535));
			else
				push_req(lgfb_pkg::MODE_LOAD, $urandom_range(fw - 1), $urandom_range(fh - 1),
					$urandom_range(9) < 6, rand_chan(), rand_chan(), rand_chan(),
					$urandom_range(3) == 0 ? tri_a + 1 : tri_a);
		end
		wait_drained();
		if (rx_press) rx_holdoff_req = 1;
		push_req(lgfb_pkg::MODE_PROCESS, $urandom_range(255), $urandom_range(255),
			$urandom_range(1), rand_chan(), rand_chan(), rand_chan(), $urandom_range(65535));
		for (int i = 0; i < 20; i++) begin
			if ($urandom_range(7) == 0)
				push_req(lgfb_pkg::MODE_READ, $urandom_range(255), $urandom_range(255),
					0, 0, 0, 0, 0);
			else
				push_req(lgfb_pkg::MODE_READ, $urandom_range(fw - 1), $urandom_range(fh - 1),
					$urandom_range(1), rand_chan(), rand_chan(), rand_chan(),
					$urandom_range(65535));
		end
	endtask

	// stimulus
	initial begin
		int phase;
		errors = 0;
		req_count = 0;
		quiet_cycles = 0;
		req_taken = 0;
		hold_send = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		rx_holdoff_req = 0;
		rx_holdoff_left = 0;
		reg_width = lgfb_pkg::FRAME_DIM_RST;
		reg_height = lgfb_pkg::FRAME_DIM_RST;
		reg_max_fill = lgfb_pkg::MAX_FILL_RST;
		reg_rad_limit = lgfb_pkg::RAD_LIMIT_RST;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: rescale edges, uncovered load, outside frame, unused mode, process and reads
		setup_frame(4, 3, 7, 12288, 0);
		push_req(lgfb_pkg::MODE_LOAD, 0, 0, 1, 0, 0, 0, 0);
		push_req(lgfb_pkg::MODE_LOAD, 1, 0, 1, 16'hffff, 16'hffff, 16'hffff, 0);
		push_req(lgfb_pkg::MODE_LOAD, 2, 0, 1, 4096, 8192, 0, 16'hffff);
		push_req(lgfb_pkg::MODE_LOAD, 3, 2, 1, 12288, 0, 0, 0);
		push_req(lgfb_pkg::MODE_LOAD, 0, 2, 0, 16'h1234, 16'h5678, 16'h9abc, 7);
		push_req(lgfb_pkg::MODE_LOAD, 255, 255, 1, 1, 2, 3, 16'hffff);
		push_req(3, 17, 5, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		push_req(lgfb_pkg::MODE_READ, 1, 0, 0, 0, 0, 0, 0);
		push_req(lgfb_pkg::MODE_PROCESS, 0, 0, 0, 0, 0, 0, 0);
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 4; x++)
				push_req(lgfb_pkg::MODE_READ, x, y, 0, 0, 0, 0, 0);
		push_req(lgfb_pkg::MODE_READ, 255, 255, 0, 0, 0, 0, 0);
		push_req(lgfb_pkg::MODE_READ, 200, 17, 0, 0, 0, 0, 0);

		// extreme settings
		setup_frame(8, 8, 255, 65535, 0);
		run_frame(1);
		setup_frame(0, 511, 0, 0, 1);
		run_frame(0);
		setup_frame(511, 1, 3, 12288, 2);
		run_frame(0);
		setup_frame(256, 2, 7, 1, 3);
		run_frame(0);

		// random small frames
		phase = 0;
		while (req_count < 750) begin
			setup_frame($urandom_range(1, 12), $urandom_range(1, 12),
				$urandom_range(3) == 0 ? 255 : $urandom_range(10),
				$urandom_range(1) ? $urandom_range(65535) : $urandom_range(8192, 16384),
				phase);
			run_frame(phase % 5 == 0);
			phase++;
		end

		wait_drained();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== lightmap_gutter_fill_and_blur_core.f =====
rtl/lgfb_pkg.sv
rtl/lgfb_div3.sv
rtl/lightmap_gutter_fill_and_blur_core.sv
rtl/lgfb_checker.sv
dv/tb_top.sv
